/* rtl/bed_pkg.sv */
`default_nettype none
package bed_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned AccW    = 9;
  localparam int unsigned CountW  = 16;
  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [ByteW-1:0] ChBackslash = 8'h5C;
  localparam logic [ByteW-1:0] ChX         = 8'h78;
  localparam logic [ByteW-1:0] ChZero      = 8'h30;
  localparam logic [ByteW-1:0] ChSeven     = 8'h37;

  typedef enum logic [2:0] {
    PhNormal = 3'd0,
    PhEsc    = 3'd1,
    PhOct2   = 3'd2,
    PhOct3   = 3'd3,
    PhHex1   = 3'd4,
    PhHex2   = 3'd5,
    PhDrop   = 3'd6
  } phase_e;

  typedef struct packed {
    phase_e              phase;
    logic [AccW-1:0]     accum;
    logic [CountW-1:0]   count;
  } state_t;

  typedef struct packed {
    logic [ByteW-1:0]  data;
    logic              last;
    logic              error;
    logic [CountW-1:0] offset;
  } result_t;

  // {hit, value}
  function automatic logic [ByteW:0] simple_escape(input logic [ByteW-1:0] b);
    logic [ByteW:0] r;
    case (b)
      8'h5C:   r = {1'b1, 8'h5C};
      8'h61:   r = {1'b1, 8'h07};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      8'h76:   r = {1'b1, 8'h0B};
      8'h22:   r = {1'b1, 8'h22};
      8'h27:   r = {1'b1, 8'h27};
      8'h3F:   r = {1'b1, 8'h3F};
      8'h20:   r = {1'b1, 8'h20};
      default: r = '0;
    endcase
    return r;
  endfunction

  // {hit, nibble}
  function automatic logic [4:0] hex_value(input logic [ByteW-1:0] b);
    logic [4:0] r;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/bed_step.sv */
`default_nettype none
module bed_step (
  input  bed_pkg::state_t             state_i,
  input  logic [bed_pkg::ByteW-1:0]   byte_i,
  input  logic                        last_i,
  output bed_pkg::state_t             state_o,
  output logic                        emit_o,
  output bed_pkg::result_t            result_o
);

  logic                       is_oct;
  logic [2:0]                 oct_d;
  logic [bed_pkg::ByteW:0]    simple;
  logic [4:0]                 hex;
  logic [bed_pkg::AccW-1:0]   oct_v;
  logic [bed_pkg::AccW-1:0]   hex_v;
  logic                       do_emit;
  logic                       do_fail;
  logic [bed_pkg::ByteW-1:0]  emit_val;
  bed_pkg::state_t            mid;

  assign is_oct = (byte_i >= bed_pkg::ChZero) && (byte_i <= bed_pkg::ChSeven);
  assign oct_d  = byte_i[2:0];
  assign simple = bed_pkg::simple_escape(byte_i);
  assign hex    = bed_pkg::hex_value(byte_i);
  assign oct_v  = {state_i.accum[bed_pkg::AccW-4:0], oct_d};
  assign hex_v  = {state_i.accum[bed_pkg::AccW-5:0], hex[3:0]};

  always_comb begin
    mid      = state_i;
    do_emit  = 1'b0;
    do_fail  = 1'b0;
    emit_val = '0;
    unique case (state_i.phase)
      bed_pkg::PhEsc: begin
        if (simple[bed_pkg::ByteW]) begin
          mid.phase = bed_pkg::PhNormal;
          do_emit   = 1'b1;
          emit_val  = simple[bed_pkg::ByteW-1:0];
        end else if (is_oct) begin
          mid.accum = {{(bed_pkg::AccW-3){1'b0}}, oct_d};
          mid.phase = bed_pkg::PhOct2;
          do_fail   = last_i;
        end else if (byte_i == bed_pkg::ChX) begin
          mid.accum = '0;
          mid.phase = bed_pkg::PhHex1;
          do_fail   = last_i;
        end else begin
          do_fail = 1'b1;
        end
      end
      bed_pkg::PhOct2: begin
        if (!is_oct) begin
          do_fail = 1'b1;
        end else begin
          mid.accum = oct_v;
          mid.phase = bed_pkg::PhOct3;
          do_fail   = last_i;
        end
      end
      bed_pkg::PhOct3: begin
        if (!is_oct || oct_v == '0 || oct_v[bed_pkg::AccW-1]) begin
          do_fail = 1'b1;
        end else begin
          mid.phase = bed_pkg::PhNormal;
          mid.accum = '0;
          do_emit   = 1'b1;
          emit_val  = oct_v[bed_pkg::ByteW-1:0];
        end
      end
      bed_pkg::PhHex1: begin
        if (!hex[4]) begin
          do_fail = 1'b1;
        end else begin
          mid.accum = {{(bed_pkg::AccW-4){1'b0}}, hex[3:0]};
          mid.phase = bed_pkg::PhHex2;
          do_fail   = last_i;
        end
      end
      bed_pkg::PhHex2: begin
        if (!hex[4] || hex_v == '0 || hex_v[bed_pkg::AccW-1]) begin
          do_fail = 1'b1;
        end else begin
          mid.phase = bed_pkg::PhNormal;
          mid.accum = '0;
          do_emit   = 1'b1;
          emit_val  = hex_v[bed_pkg::ByteW-1:0];
        end
      end
      bed_pkg::PhDrop: begin
        if (last_i) begin
          mid = '{phase: bed_pkg::PhNormal, accum: '0, count: '0};
        end
      end
      default: begin
        // normal phase, and the unused code
        mid.phase = bed_pkg::PhNormal;
        if (byte_i == bed_pkg::ChBackslash) begin
          if (last_i) begin
            do_fail = 1'b1;
          end else begin
            mid.phase = bed_pkg::PhEsc;
          end
        end else begin
          do_emit  = 1'b1;
          emit_val = byte_i;
        end
      end
    endcase
  end

  always_comb begin
    state_o  = mid;
    emit_o   = do_emit || do_fail;
    result_o = '{data: emit_val, last: last_i, error: 1'b0, offset: '0};
    if (do_fail) begin
      result_o = '{data: '0, last: 1'b1, error: 1'b1, offset: state_i.count};
      if (last_i) begin
        state_o = '{phase: bed_pkg::PhNormal, accum: '0, count: '0};
      end else begin
        state_o.phase = bed_pkg::PhDrop;
        state_o.accum = '0;
      end
    end else if (do_emit) begin
      if (last_i) begin
        state_o = '{phase: bed_pkg::PhNormal, accum: '0, count: '0};
      end else if (mid.count != bed_pkg::CountMax) begin
        state_o.count = mid.count + bed_pkg::CountW'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/bed_obuf.sv */
`default_nettype none
module bed_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bed_pkg::result_t  data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              stall_i,
  output bed_pkg::result_t  data_o
);

  logic             out_vld_q, out_vld_d;
  logic             skid_vld_q, skid_vld_d;
  bed_pkg::result_t out_q, out_d;
  bed_pkg::result_t skid_q, skid_d;
  logic             pop;

  assign pop = out_vld_q && !stall_i;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (!out_vld_q || pop) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = push_i;
        skid_d     = push_i ? data_i : skid_q;
      end else begin
        out_vld_d = push_i;
        out_d     = push_i ? data_i : out_q;
      end
    end else if (push_i) begin
      // head is stalled, park the new beat
      skid_vld_d = 1'b1;
      skid_d     = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_vld_q;
  assign valid_o = out_vld_q;
  assign data_o  = out_q;

endmodule
`default_nettype wire

/* rtl/backslash_escape_decoder.sv */
`default_nettype none
// Decodes C-style backslash escapes in a byte stream, one input beat per clock
// with no bubbles. Each beat updates the small phase/digit/count state in the
// same cycle and writes at most one result into a two-entry output buffer
// (an output register and a skid register) that presents it. The input
// stalls only while both buffer entries are held by a stalled output. An
// error result has out_last set, carries the output position of the bad
// backslash, and the rest of that string is dropped without results.
module backslash_escape_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic        error_o,
  output logic [15:0] error_offset_o
);

  bed_pkg::state_t  state_q, state_d;
  bed_pkg::result_t res, head;
  logic             emit;
  logic             accept;
  logic             full;

  assign accept = in_valid_i && !full;

  bed_step u_step (
    .state_i  (state_q),
    .byte_i   (in_byte_i),
    .last_i   (in_last_i),
    .state_o  (state_d),
    .emit_o   (emit),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: bed_pkg::PhNormal, accum: '0, count: '0};
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  bed_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && emit),
    .data_i  (res),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (head)
  );

  assign in_stall_o     = full;
  assign out_byte_o     = head.data;
  assign out_last_o     = head.last;
  assign error_o        = head.error;
  assign error_offset_o = head.offset;

endmodule
`default_nettype wire

/* rtl/bed_checker.sv */
`default_nettype none
module bed_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_byte_o,
  input logic        out_last_o,
  input logic        error_o,
  input logic [15:0] error_offset_o
);

  // a held result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> out_last_o && out_byte_o == 8'h00)
    else $error("error beat without last or with data");

  a_ok_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !error_o |-> error_offset_o == 16'h0000)
    else $error("offset set on a good beat");

  // input backpressure only follows a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  // a full buffer always holds a valid head
  a_full_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

bind backslash_escape_decoder bed_checker u_bed_checker (.*);
`default_nettype wire
